>>> rtl/serial_link_handshake_field_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the serial link handshake field parser
// Shared property shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINK_HANDSHAKE_FIELD_PARSER_MACROS_SVH
`define SERIAL_LINK_HANDSHAKE_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, ignored while reset is low
`define SLHFP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked through reset
`define SLHFP_ASSERT_NXT(name, clk, ante, cons, msg) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/slhfp_pkg.sv
// ----------------------------------------------------------------------------
// slhfp_pkg
// Types, constants and reply tables for the serial link handshake parser.
// ----------------------------------------------------------------------------
package slhfp_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int NAME_CAPACITY = 28;
    localparam int SLOT_COUNT    = 12;
    localparam int LINE_AW       = $clog2(LINE_CAPACITY);
    localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
    localparam int FLEN_W        = $clog2(NAME_CAPACITY + 1);
    localparam int FC_DEPTH      = SLOT_COUNT * NAME_CAPACITY;
    localparam int FC_AW         = $clog2(FC_DEPTH);
    localparam int SLOT_W        = 4;
    localparam int IDX_W         = 5;
    localparam int MAX_OUT       = 6;
    localparam int REP_CW        = 3;
    localparam int ITER_W        = 3;

    localparam logic [7:0]  UNIT_SEP      = 8'h1F;
    localparam logic [7:0]  CHAR_CR       = 8'h0D;
    localparam logic [7:0]  CHAR_LF       = 8'h0A;
    localparam logic [31:0] TIMEOUT_RESET = 32'd3000000;

    typedef enum logic [2:0] {
        STG_GREET_HOST   = 3'd0,
        STG_GREET_DEV    = 3'd1,
        STG_CONFIRM_HOST = 3'd2,
        STG_CONFIRM_DEV  = 3'd3,
        STG_READY        = 3'd4,
        STG_ERROR_WAIT   = 3'd5
    } t_stage;

    typedef enum logic [1:0] {
        OP_BYTE   = 2'd0,
        OP_TICK   = 2'd1,
        OP_READ   = 2'd2,
        OP_IGNORE = 2'd3
    } t_op;

    typedef enum logic {
        KIND_REPLY = 1'b0,
        KIND_FIELD = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        MSG_HELLO,
        MSG_LINKED,
        MSG_ACK,
        MSG_NAK,
        MSG_BEAT
    } t_msg;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_STEP,
        CS_SCAN_RD,
        CS_SCAN_CHK,
        CS_COPY_RD,
        CS_COPY_WR,
        CS_SPLIT_END,
        CS_EMIT,
        CS_READ_OUT
    } t_ctrl_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic   item_start;
        logic   take_byte;
        logic   tick;
        logic   read_issue;
        logic   stage_we;
        t_stage stage_val;
        logic   arm;
        logic   clear_line;
        logic   clear_all;
        logic   set_stats;
        logic   send_en;
        t_msg   send_msg;
        logic   split_start;
        logic   scan_step;
        logic   copy_wr;
        logic   field_done;
        logic   line_rd_copy;
        logic   out_load_rep;
        logic   out_load_field;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        t_stage stage;
        logic   line_ready;
        logic   dl_zero;
        logic   tmo_zero;
        logic   is_jb;
        logic   is_p06;
        logic   is_p15;
        logic   is_d11;
        logic   is_c30;
        logic   is_c31;
        logic   is_h30;
        logic   scan_more;
        logic   is_sep;
        logic   slot_ok;
        logic   copy_more;
        logic   split_ok;
        logic   rep_empty;
        logic   emit_last;
        logic   out_busy;
    } t_stat;

    function automatic logic [FLEN_W-1:0] slot_cap(input logic [SLOT_W-1:0] slot);
        case (slot)
            4'd0, 4'd1:   slot_cap = FLEN_W'(NAME_CAPACITY);
            4'd8, 4'd10:  slot_cap = FLEN_W'(8);
            default:      slot_cap = FLEN_W'(6);
        endcase
    endfunction

    function automatic logic [REP_CW-1:0] msg_len(input t_msg m);
        case (m)
            MSG_HELLO:        msg_len = REP_CW'(6);
            MSG_ACK, MSG_NAK: msg_len = REP_CW'(5);
            default:          msg_len = REP_CW'(4);
        endcase
    endfunction

    function automatic logic [7:0] msg_byte(input t_msg m, input logic [REP_CW-1:0] k);
        logic [7:0] b;
        b = 8'h00;
        case (m)
            MSG_HELLO: begin
                case (k)
                    3'd0:    b = "P";
                    3'd1:    b = "0";
                    3'd2:    b = "0";
                    3'd3:    b = "1";
                    3'd4:    b = CHAR_CR;
                    default: b = CHAR_LF;
                endcase
            end
            MSG_LINKED: begin
                case (k)
                    3'd0:    b = "L";
                    3'd1:    b = 8'h06;
                    3'd2:    b = CHAR_CR;
                    default: b = CHAR_LF;
                endcase
            end
            MSG_ACK, MSG_NAK: begin
                case (k)
                    3'd0:    b = "D";
                    3'd1:    b = 8'h11;
                    3'd2:    b = (m == MSG_ACK) ? 8'h06 : 8'h15;
                    3'd3:    b = CHAR_CR;
                    default: b = CHAR_LF;
                endcase
            end
            default: begin
                case (k)
                    3'd0:    b = "H";
                    3'd1:    b = 8'h31;
                    3'd2:    b = CHAR_CR;
                    default: b = CHAR_LF;
                endcase
            end
        endcase
        msg_byte = b;
    endfunction

endpackage

>>> rtl/slhfp_in_if.sv
// ----------------------------------------------------------------------------
// slhfp_in_if
// Input channel: one received byte, tick or field read per transaction.
// ----------------------------------------------------------------------------
interface slhfp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;
    logic [3:0] field_slot;
    logic [4:0] char_index;

    modport source (output valid, op, data_byte, field_slot, char_index, input ready);
    modport sink   (input valid, op, data_byte, field_slot, char_index, output ready);
endinterface

>>> rtl/slhfp_out_if.sv
// ----------------------------------------------------------------------------
// slhfp_out_if
// Output channel: one reply byte or field character per transaction.
// ----------------------------------------------------------------------------
interface slhfp_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;
    logic       last;
    logic [2:0] stage;
    logic       show_stats;

    modport source (output valid, kind, out_byte, last, stage, show_stats, input ready);
    modport sink   (input valid, kind, out_byte, last, stage, show_stats, output ready);
endinterface

>>> rtl/slhfp_datapath.sv
// ----------------------------------------------------------------------------
// slhfp_datapath
// Line buffer, field store, deadline counter, reply queue and output register.
// ----------------------------------------------------------------------------
module slhfp_datapath
    import slhfp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [7:0]          i_data_byte,
    input  logic [SLOT_W-1:0]   i_field_slot,
    input  logic [IDX_W-1:0]    i_char_index,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata,
    output logic [31:0]         o_timeout,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_out_kind,
    output logic [7:0]          o_out_byte,
    output logic                o_out_last,
    output logic [2:0]          o_out_stage,
    output logic                o_out_stats
);

    logic [31:0]             r_timeout;
    t_stage                  r_stage;
    logic [LEN_W-1:0]        r_len;
    logic                    r_ready;
    logic [31:0]             r_deadline;
    logic [FLEN_W-1:0]       r_flen [SLOT_COUNT];
    logic                    r_stats;
    logic [7:0]              r_prev;
    logic [7:0]              r_hdr [3];
    logic [7:0]              r_line [LINE_CAPACITY];
    logic [7:0]              r_line_q;
    logic [7:0]              r_fc [FC_DEPTH];
    logic [7:0]              r_fc_q;
    logic                    r_fc_ok;
    logic [7:0]              r_rep [MAX_OUT];
    logic [REP_CW-1:0]       r_rep_cnt;
    logic [REP_CW-1:0]       r_emit_k;
    logic [LEN_W-1:0]        r_i;
    logic [LEN_W-1:0]        r_start;
    logic [LEN_W-1:0]        r_count;
    logic [SLOT_W-1:0]       r_first;
    logic [SLOT_W-1:0]       r_nsl;
    logic [SLOT_W-1:0]       r_cur_slot;
    logic [FLEN_W-1:0]       r_seg;
    logic [FLEN_W-1:0]       r_k;
    logic                    r_out_valid;
    logic                    r_out_kind;
    logic [7:0]              r_out_byte;
    logic                    r_out_last;
    t_stage                  r_out_stage;
    logic                    r_out_stats;

    logic [LINE_AW-1:0]      w_wpos;
    logic [LEN_W-1:0]        w_wpos_ext;
    logic                    w_crlf;
    logic [LEN_W-1:0]        w_copy_addr;
    logic [LINE_AW-1:0]      w_line_raddr;
    logic [LEN_W-1:0]        w_seg_raw;
    logic [FLEN_W-1:0]       w_seg_cap;
    logic [FLEN_W-1:0]       w_cap;
    logic [SLOT_W-1:0]       w_new_slot;
    logic [FC_AW-1:0]        w_fc_waddr;
    logic [FC_AW-1:0]        w_fc_raddr;
    logic                    w_rd_ok;
    logic [FLEN_W-1:0]       w_rd_len;
    logic [7:0]              n_rep [MAX_OUT];
    logic [REP_CW-1:0]       n_rep_cnt;
    logic [7:0]              w_c0;
    logic [7:0]              w_c1;
    logic [7:0]              w_c2;

    // Byte placement: wrap a full buffer, detect CR LF against the previous byte
    assign w_wpos     = (r_len >= LEN_W'(LINE_CAPACITY)) ? '0 : r_len[LINE_AW-1:0];
    assign w_wpos_ext = LEN_W'(w_wpos);
    assign w_crlf     = (w_wpos != '0) && (r_prev == CHAR_CR) && (i_data_byte == CHAR_LF);

    // Header characters read as zero past the line length
    assign w_c0 = (r_len > LEN_W'(0)) ? r_hdr[0] : 8'h00;
    assign w_c1 = (r_len > LEN_W'(1)) ? r_hdr[1] : 8'h00;
    assign w_c2 = (r_len > LEN_W'(2)) ? r_hdr[2] : 8'h00;

    // Split addressing
    assign w_copy_addr  = r_start + LEN_W'(r_k);
    assign w_line_raddr = i_cmd.line_rd_copy ? w_copy_addr[LINE_AW-1:0] : r_i[LINE_AW-1:0];
    assign w_seg_raw    = (r_i > r_start) ? (r_i - r_start) : '0;
    assign w_new_slot   = r_first + r_count[SLOT_W-1:0];
    assign w_cap        = slot_cap(w_new_slot);
    assign w_seg_cap    = (w_seg_raw > LEN_W'(w_cap)) ? w_cap : w_seg_raw[FLEN_W-1:0];
    assign w_fc_waddr   = FC_AW'(r_cur_slot) * FC_AW'(NAME_CAPACITY) + FC_AW'(r_k);

    // Field read lookup
    assign w_rd_len   = (i_field_slot < SLOT_W'(SLOT_COUNT)) ? r_flen[i_field_slot] : '0;
    assign w_rd_ok    = (i_field_slot < SLOT_W'(SLOT_COUNT)) &&
                        (FLEN_W'(i_char_index) < w_rd_len);
    assign w_fc_raddr = w_rd_ok ?
                        (FC_AW'(i_field_slot) * FC_AW'(NAME_CAPACITY) + FC_AW'(i_char_index))
                        : '0;

    // Append a reply message, capped at the queue depth
    always_comb begin
        int off;
        n_rep     = r_rep;
        n_rep_cnt = r_rep_cnt;
        off       = 0;
        if (i_cmd.send_en) begin
            for (int j = 0; j < MAX_OUT; j++) begin
                off = j - int'(r_rep_cnt);
                if (off >= 0 && off < int'(msg_len(i_cmd.send_msg))) begin
                    n_rep[j] = msg_byte(i_cmd.send_msg, REP_CW'(off));
                end
            end
            if (int'(r_rep_cnt) + int'(msg_len(i_cmd.send_msg)) > MAX_OUT) begin
                n_rep_cnt = REP_CW'(MAX_OUT);
            end else begin
                n_rep_cnt = r_rep_cnt + msg_len(i_cmd.send_msg);
            end
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    // Link stage, stats flag, deadline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage    <= STG_GREET_HOST;
            r_stats    <= 1'b0;
            r_deadline <= '0;
        end else begin
            if (i_cmd.clear_all) begin
                r_stage <= STG_GREET_HOST;
                r_stats <= 1'b0;
            end else begin
                if (i_cmd.stage_we) begin
                    r_stage <= i_cmd.stage_val;
                end
                if (i_cmd.set_stats) begin
                    r_stats <= 1'b1;
                end
            end
            if (i_cmd.arm) begin
                r_deadline <= r_timeout;
            end else if (i_cmd.tick && (r_deadline != '0)) begin
                r_deadline <= r_deadline - 32'd1;
            end
        end
    end

    // Line length and completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_ready <= 1'b0;
        end else if (i_cmd.clear_all || i_cmd.clear_line) begin
            r_len   <= '0;
            r_ready <= 1'b0;
        end else if (i_cmd.take_byte && !r_ready) begin
            r_len   <= w_wpos_ext + LEN_W'(1);
            r_ready <= w_crlf;
        end
    end

    // Line bytes, header copies and previous byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte && !r_ready) begin
            r_line[w_wpos] <= i_data_byte;
            r_prev         <= i_data_byte;
            if (w_wpos_ext < LEN_W'(3)) begin
                r_hdr[w_wpos_ext[1:0]] <= i_data_byte;
            end
        end
        r_line_q <= r_line[w_line_raddr];
    end

    // Field lengths
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_all) begin
            for (int s = 0; s < SLOT_COUNT; s++) begin
                r_flen[s] <= '0;
            end
        end else if (i_cmd.field_done) begin
            r_flen[r_cur_slot] <= r_seg;
        end
    end

    // Field character store
    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_wr) begin
            r_fc[w_fc_waddr] <= r_line_q;
        end
        if (i_cmd.read_issue) begin
            r_fc_q  <= r_fc[w_fc_raddr];
            r_fc_ok <= w_rd_ok;
        end
    end

    // Split walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.split_start) begin
            r_i     <= '0;
            r_start <= LEN_W'(3);
            r_count <= '0;
            r_first <= w_c2[0] ? SLOT_W'(3) : SLOT_W'(0);
            r_nsl   <= w_c2[0] ? SLOT_W'(9) : SLOT_W'(3);
        end else if (i_cmd.scan_step) begin
            if (o_stat.is_sep && o_stat.slot_ok) begin
                r_cur_slot <= w_new_slot;
                r_seg      <= w_seg_cap;
                r_k        <= '0;
            end else begin
                if (o_stat.is_sep) begin
                    r_count <= r_count + LEN_W'(1);
                    r_start <= r_i + LEN_W'(1);
                end
                r_i <= r_i + LEN_W'(1);
            end
        end else if (i_cmd.field_done) begin
            r_count <= r_count + LEN_W'(1);
            r_start <= r_i + LEN_W'(1);
            r_i     <= r_i + LEN_W'(1);
        end else if (i_cmd.copy_wr) begin
            r_k <= r_k + FLEN_W'(1);
        end
    end

    // Reply queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_cnt <= '0;
            r_emit_k  <= '0;
        end else if (i_cmd.item_start) begin
            r_rep_cnt <= '0;
            r_emit_k  <= '0;
        end else begin
            r_rep_cnt <= n_rep_cnt;
            if (i_cmd.out_load_rep) begin
                r_emit_k <= r_emit_k + REP_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep <= n_rep;
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load_rep || i_cmd.out_load_field) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_rep) begin
            r_out_kind  <= KIND_REPLY;
            r_out_byte  <= r_rep[r_emit_k];
            r_out_last  <= o_stat.emit_last;
            r_out_stage <= r_stage;
            r_out_stats <= r_stats;
        end else if (i_cmd.out_load_field) begin
            r_out_kind  <= KIND_FIELD;
            r_out_byte  <= r_fc_ok ? r_fc_q : 8'h00;
            r_out_last  <= 1'b1;
            r_out_stage <= r_stage;
            r_out_stats <= r_stats;
        end
    end

    // Status back to the controller
    always_comb begin
        o_stat            = '0;
        o_stat.stage      = r_stage;
        o_stat.line_ready = r_ready;
        o_stat.dl_zero    = (r_deadline == '0);
        o_stat.tmo_zero   = (r_timeout == '0);
        o_stat.is_jb      = (w_c0 == "J") && (w_c1 == "B") && (w_c2 == 8'h05);
        o_stat.is_p06     = (w_c0 == "P") && (w_c1 == 8'h06);
        o_stat.is_p15     = (w_c0 == "P") && (w_c1 == 8'h15);
        o_stat.is_d11     = (w_c0 == "D") && (w_c1 == 8'h11);
        o_stat.is_c30     = (w_c2 == 8'h30);
        o_stat.is_c31     = (w_c2 == 8'h31);
        o_stat.is_h30     = (w_c0 == "H") && (w_c1 == 8'h30);
        o_stat.scan_more  = (r_i < r_len);
        o_stat.is_sep     = (r_line_q == UNIT_SEP);
        o_stat.slot_ok    = (r_count < LEN_W'(r_nsl));
        o_stat.copy_more  = (r_k < r_seg);
        o_stat.split_ok   = (r_count == LEN_W'(r_nsl));
        o_stat.rep_empty  = (r_rep_cnt == '0);
        o_stat.emit_last  = (r_emit_k == r_rep_cnt - REP_CW'(1));
        o_stat.out_busy   = r_out_valid;
    end

    assign o_timeout   = r_timeout;
    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;
    assign o_out_stage = r_out_stage;
    assign o_out_stats = r_out_stats;

endmodule

>>> rtl/slhfp_ctrl.sv
// ----------------------------------------------------------------------------
// slhfp_ctrl
// Sequencer: accepts a transaction, runs link stage steps, walks a stats
// line split and emits the queued results.
// ----------------------------------------------------------------------------
module slhfp_ctrl
    import slhfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_op,
    output logic       o_in_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    t_ctrl_state       r_state;
    t_ctrl_state       n_state;
    logic [ITER_W-1:0] r_iter;
    logic [ITER_W-1:0] n_iter;
    t_cmd              w_step;
    logic              w_step_split;
    logic              w_step_chg;
    t_op               w_op;

    assign w_op = t_op'(i_in_op);

    // One pass of the link stage logic
    always_comb begin
        logic   arm_now;
        t_stage nxt;
        arm_now      = 1'b0;
        w_step       = '0;
        w_step_split = 1'b0;
        unique case (i_stat.stage)
            STG_ERROR_WAIT: begin
                if (i_stat.dl_zero) begin
                    w_step.clear_all = 1'b1;
                end
            end
            STG_GREET_HOST: begin
                if (i_stat.line_ready) begin
                    if (i_stat.is_jb) begin
                        w_step.stage_we  = 1'b1;
                        w_step.stage_val = STG_GREET_DEV;
                    end
                    w_step.clear_line = 1'b1;
                end
            end
            STG_GREET_DEV: begin
                w_step.send_en   = 1'b1;
                w_step.send_msg  = MSG_HELLO;
                w_step.stage_we  = 1'b1;
                w_step.stage_val = STG_CONFIRM_HOST;
                w_step.arm       = 1'b1;
            end
            STG_CONFIRM_HOST: begin
                if (i_stat.line_ready) begin
                    if (i_stat.is_p06) begin
                        w_step.stage_we  = 1'b1;
                        w_step.stage_val = STG_CONFIRM_DEV;
                    end else if (i_stat.is_p15) begin
                        w_step.stage_we  = 1'b1;
                        w_step.stage_val = STG_ERROR_WAIT;
                        w_step.arm       = 1'b1;
                        arm_now          = 1'b1;
                    end
                    w_step.clear_line = 1'b1;
                end
                // Deadline seen after the line, including a fresh arm
                if (arm_now ? i_stat.tmo_zero : i_stat.dl_zero) begin
                    w_step.clear_line = 1'b1;
                    w_step.stage_we   = 1'b1;
                    w_step.stage_val  = STG_ERROR_WAIT;
                    w_step.arm        = 1'b1;
                end
            end
            STG_CONFIRM_DEV: begin
                w_step.send_en   = 1'b1;
                w_step.send_msg  = MSG_LINKED;
                w_step.stage_we  = 1'b1;
                w_step.stage_val = STG_READY;
                w_step.arm       = 1'b1;
            end
            STG_READY: begin
                w_step.set_stats = 1'b1;
                if (!i_stat.line_ready) begin
                    if (i_stat.dl_zero) begin
                        w_step.stage_we  = 1'b1;
                        w_step.stage_val = STG_ERROR_WAIT;
                        w_step.arm       = 1'b1;
                    end
                end else if (i_stat.is_d11 && (i_stat.is_c30 || i_stat.is_c31)) begin
                    w_step.split_start = 1'b1;
                    w_step_split       = 1'b1;
                end else begin
                    if (i_stat.is_d11) begin
                        w_step.send_en  = 1'b1;
                        w_step.send_msg = MSG_NAK;
                    end else if (i_stat.is_h30) begin
                        w_step.send_en  = 1'b1;
                        w_step.send_msg = MSG_BEAT;
                        w_step.arm      = 1'b1;
                    end
                    w_step.clear_line = 1'b1;
                end
            end
            default: begin
                w_step.stage_we  = 1'b1;
                w_step.stage_val = STG_GREET_HOST;
            end
        endcase
        if (w_step.clear_all) begin
            nxt = STG_GREET_HOST;
        end else if (w_step.stage_we) begin
            nxt = w_step.stage_val;
        end else begin
            nxt = i_stat.stage;
        end
        w_step_chg = (nxt != i_stat.stage);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        unique case (r_state)
            CS_IDLE: begin
                n_iter = '0;
                if (i_in_valid) begin
                    case (w_op)
                        OP_BYTE, OP_TICK: n_state = CS_STEP;
                        OP_READ:          n_state = CS_READ_OUT;
                        default:          n_state = CS_IDLE;
                    endcase
                end
            end
            CS_STEP: begin
                if (w_step_split) begin
                    n_state = CS_SCAN_RD;
                end else if (w_step_chg && (r_iter != '1)) begin
                    n_iter = r_iter + ITER_W'(1);
                end else begin
                    n_state = CS_EMIT;
                end
            end
            CS_SCAN_RD: begin
                n_state = i_stat.scan_more ? CS_SCAN_CHK : CS_SPLIT_END;
            end
            CS_SCAN_CHK: begin
                n_state = (i_stat.is_sep && i_stat.slot_ok) ? CS_COPY_RD : CS_SCAN_RD;
            end
            CS_COPY_RD: begin
                n_state = i_stat.copy_more ? CS_COPY_WR : CS_SCAN_RD;
            end
            CS_COPY_WR: begin
                n_state = CS_COPY_RD;
            end
            CS_SPLIT_END: begin
                n_state = CS_EMIT;
            end
            CS_EMIT: begin
                if (i_stat.rep_empty) begin
                    n_state = CS_IDLE;
                end else if (!i_stat.out_busy && i_stat.emit_last) begin
                    n_state = CS_IDLE;
                end
            end
            CS_READ_OUT: begin
                if (!i_stat.out_busy) begin
                    n_state = CS_IDLE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            CS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.item_start = 1'b1;
                    o_cmd.take_byte  = (w_op == OP_BYTE);
                    o_cmd.tick       = (w_op == OP_TICK);
                    o_cmd.read_issue = (w_op == OP_READ);
                end
            end
            CS_STEP:     o_cmd = w_step;
            CS_SCAN_RD:  o_cmd.line_rd_copy = 1'b0;
            CS_SCAN_CHK: o_cmd.scan_step = 1'b1;
            CS_COPY_RD: begin
                if (i_stat.copy_more) begin
                    o_cmd.line_rd_copy = 1'b1;
                end else begin
                    o_cmd.field_done = 1'b1;
                end
            end
            CS_COPY_WR:  o_cmd.copy_wr = 1'b1;
            CS_SPLIT_END: begin
                o_cmd.send_en    = 1'b1;
                o_cmd.send_msg   = i_stat.split_ok ? MSG_ACK : MSG_NAK;
                o_cmd.clear_line = 1'b1;
            end
            CS_EMIT: begin
                o_cmd.out_load_rep = !i_stat.rep_empty && !i_stat.out_busy;
            end
            CS_READ_OUT: begin
                o_cmd.out_load_field = !i_stat.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

endmodule

>>> rtl/serial_link_handshake_field_parser.sv
// A byte or tick runs link stage steps, then each reply byte is loaded into the output
// register once it is free. A stats line also walks the line bytes through the line
// buffer read port and copies field characters through the field store write port.
// A field read yields one character. One transaction is in work at a time.
// Reset: synchronous, active low; control state clears at once, the line buffer and field
// store hold unknown data until written and get no clearing pass.
// ----------------------------------------------------------------------------
// serial_link_handshake_field_parser
// Device side of a line-based host handshake with a stored stats field table.
// ----------------------------------------------------------------------------
module serial_link_handshake_field_parser
    import slhfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    slhfp_in_if.sink    i_in,
    slhfp_out_if.source o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd        w_cmd;
    t_stat       w_stat;
    logic        w_cfg_we;
    logic [31:0] w_timeout;

    // APB: single register, decoded at any offset with paddr[2] low
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? w_timeout : '0;

    slhfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_op    (i_in.op),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    slhfp_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_data_byte  (i_in.data_byte),
        .i_field_slot (i_in.field_slot),
        .i_char_index (i_in.char_index),
        .i_cfg_we     (w_cfg_we),
        .i_cfg_wdata  (pwdata),
        .o_timeout    (w_timeout),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_out_kind   (o_out.kind),
        .o_out_byte   (o_out.out_byte),
        .o_out_last   (o_out.last),
        .o_out_stage  (o_out.stage),
        .o_out_stats  (o_out.show_stats)
    );

endmodule

>>> rtl/slhfp_checker.sv
// ----------------------------------------------------------------------------
// slhfp_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "serial_link_handshake_field_parser_macros.svh"

module slhfp_checker
    import slhfp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_kind,
    input logic [7:0] i_byte,
    input logic       i_last,
    input logic [2:0] i_stage,
    input logic       i_stats
);

    // Nothing offered right after reset
    `SLHFP_ASSERT_NXT(a_rst_idle, i_clk, !i_rst_n, !i_valid, "result valid after reset")

    // Stalled result holds
    `SLHFP_ASSERT_NXT(a_hold, i_clk, i_rst_n && i_valid && !i_ready,
        !i_rst_n || (i_valid && $stable(i_byte) && $stable(i_last)), "stalled result changed")

    // A field read is a single-result transaction
    `SLHFP_ASSERT_IMP(a_read_last, i_clk, i_rst_n, i_valid && i_kind, i_last,
        "field read not marked last")

    // Stats screen only once the link reached ready, until the error wait clears it
    `SLHFP_ASSERT_IMP(a_stats_stage, i_clk, i_rst_n, i_valid && i_stats,
        i_stage == 3'(STG_READY) || i_stage == 3'(STG_ERROR_WAIT), "stats shown in wrong stage")

endmodule

bind serial_link_handshake_field_parser slhfp_checker u_slhfp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_kind  (o_out.kind),
    .i_byte  (o_out.out_byte),
    .i_last  (o_out.last),
    .i_stage (o_out.stage),
    .i_stats (o_out.show_stats)
);

>>> bench/serial_link_handshake_field_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// serial_link_handshake_field_parser_test
// Drives host bytes, ticks and field reads into the link parser through the
// valid/ready channels, tracks link stages and stored fields in a scoreboard
// and checks every reply byte and field character in order.
// ----------------------------------------------------------------------------
module serial_link_handshake_field_parser_test;
    import slhfp_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 300;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        t_kind        kind;
        logic [7:0]   data;
        logic         last;
        t_stage       stage;
        logic         shown;
    } t_reply;

    // Link tracker: its own copy of stage, line, deadline and field table
    class link_scoreboard;
        t_reply      expected_q[$];
        int          errors;
        logic [31:0] timeout_ticks;
        t_stage      stage;
        logic [7:0]  line_buf[LINE_CAPACITY];
        int          line_len;
        bit          line_rdy;
        logic [31:0] deadline;
        logic [7:0]  fchars[SLOT_COUNT * NAME_CAPACITY];
        int          flen[SLOT_COUNT];
        bit          shown;
        logic [7:0]  reply_q[$];

        function new();
            timeout_ticks = TIMEOUT_RESET;
            deadline = 0;
            errors = 0;
            clear_all();
        endfunction

        function int capacity(int slot);
            int caps[SLOT_COUNT] = '{28, 28, 6, 6, 6, 6, 6, 6, 8, 6, 8, 6};
            return caps[slot];
        endfunction

        function logic [7:0] line_char(int i);
            if (i < line_len) return line_buf[i];
            return 8'h00;
        endfunction

        function void clear_line();
            line_len = 0;
            line_rdy = 0;
        endfunction

        function void clear_all();
            stage = STG_GREET_HOST;
            shown = 0;
            clear_line();
            foreach (flen[i]) flen[i] = 0;
        endfunction

        function void send(t_msg m);
            logic [7:0] s[$];
            case (m)
                MSG_HELLO:  s = '{8'h50, 8'h30, 8'h30, 8'h31, CHAR_CR, CHAR_LF};
                MSG_LINKED: s = '{8'h4C, 8'h06, CHAR_CR, CHAR_LF};
                MSG_ACK:    s = '{8'h44, 8'h11, 8'h06, CHAR_CR, CHAR_LF};
                MSG_NAK:    s = '{8'h44, 8'h11, 8'h15, CHAR_CR, CHAR_LF};
                default:    s = '{8'h48, 8'h31, CHAR_CR, CHAR_LF};
            endcase
            foreach (s[i])
                if (reply_q.size() < MAX_OUT) reply_q.push_back(s[i]);
        endfunction

        // Split the line at unit separators into slots starting at first
        function bit split(int first, int nslots);
            int count;
            int start;
            int seg;
            int slot;
            count = 0;
            start = 3;
            for (int i = 0; i < line_len; i++) begin
                if (line_buf[i] != UNIT_SEP) continue;
                if (count < nslots) begin
                    slot = first + count;
                    seg = (i > start) ? i - start : 0;
                    if (seg > capacity(slot)) seg = capacity(slot);
                    for (int k = 0; k < seg; k++)
                        fchars[slot * NAME_CAPACITY + k] = line_buf[start + k];
                    flen[slot] = seg;
                end
                count++;
                start = i + 1;
            end
            return count == nslots;
        endfunction

        function void ready_line();
            bit ok;
            ok = 0;
            if (line_char(0) == 8'h44 && line_char(1) == 8'h11) begin
                if (line_char(2) == 8'h30) ok = split(0, 3);
                else if (line_char(2) == 8'h31) ok = split(3, 9);
                send(ok ? MSG_ACK : MSG_NAK);
            end else if (line_char(0) == 8'h48 && line_char(1) == 8'h30) begin
                send(MSG_BEAT);
                deadline = timeout_ticks;
            end
            clear_line();
        endfunction

        function void step_stage();
            case (stage)
                STG_ERROR_WAIT: begin
                    if (deadline == 0) clear_all();
                end
                STG_GREET_HOST: begin
                    if (line_rdy) begin
                        if (line_char(0) == 8'h4A && line_char(1) == 8'h42 &&
                            line_char(2) == 8'h05) stage = STG_GREET_DEV;
                        clear_line();
                    end
                end
                STG_GREET_DEV: begin
                    send(MSG_HELLO);
                    stage = STG_CONFIRM_HOST;
                    deadline = timeout_ticks;
                end
                STG_CONFIRM_HOST: begin
                    if (line_rdy) begin
                        if (line_char(0) == 8'h50 && line_char(1) == 8'h06) begin
                            stage = STG_CONFIRM_DEV;
                        end else if (line_char(0) == 8'h50 && line_char(1) == 8'h15) begin
                            stage = STG_ERROR_WAIT;
                            deadline = timeout_ticks;
                        end
                        clear_line();
                    end
                    if (deadline == 0) begin
                        clear_line();
                        stage = STG_ERROR_WAIT;
                        deadline = timeout_ticks;
                    end
                end
                STG_CONFIRM_DEV: begin
                    send(MSG_LINKED);
                    stage = STG_READY;
                    deadline = timeout_ticks;
                end
                STG_READY: begin
                    shown = 1;
                    if (!line_rdy) begin
                        if (deadline == 0) begin
                            stage = STG_ERROR_WAIT;
                            deadline = timeout_ticks;
                        end
                    end else begin
                        ready_line();
                    end
                end
                default: stage = STG_GREET_HOST;
            endcase
        endfunction

        function void settle();
            t_stage prev;
            for (int n = 0; n < 8; n++) begin
                prev = stage;
                step_stage();
                if (stage == prev) break;
            end
        endfunction

        function void take_byte(logic [7:0] b);
            if (line_rdy) return;
            if (line_len >= LINE_CAPACITY) line_len = 0;
            line_buf[line_len] = b;
            line_len++;
            if (line_len >= 2 && line_buf[line_len-2] == CHAR_CR &&
                line_buf[line_len-1] == CHAR_LF) line_rdy = 1;
        endfunction

        // Note an accepted input transaction and queue its replies
        function void note_input(t_op op, logic [7:0] b, logic [3:0] slot, logic [4:0] idx);
            t_reply r;
            reply_q.delete();
            if (op == OP_READ) begin
                r.kind = KIND_FIELD;
                r.data = 8'h00;
                if (slot < SLOT_COUNT && idx < flen[slot])
                    r.data = fchars[slot * NAME_CAPACITY + idx];
                r.last = 1;
                r.stage = stage;
                r.shown = shown;
                expected_q.push_back(r);
                return;
            end
            if (op == OP_BYTE) begin
                take_byte(b);
                settle();
            end else if (op == OP_TICK) begin
                if (deadline != 0) deadline--;
                settle();
            end else begin
                return;
            end
            foreach (reply_q[k]) begin
                r.kind = KIND_REPLY;
                r.data = reply_q[k];
                r.last = (k == reply_q.size() - 1);
                r.stage = stage;
                r.shown = shown;
                expected_q.push_back(r);
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // Check one result transaction against the oldest expectation
        task check(logic kind, logic [7:0] data, logic last, logic [2:0] stg, logic shw);
            t_reply r;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result kind=%0d byte=%02h", kind, data));
                return;
            end
            r = expected_q.pop_front();
            if (kind !== r.kind || data !== r.data || last !== r.last ||
                stg !== r.stage || shw !== r.shown)
                report($sformatf("got k%0d %02h l%0d s%0d v%0d, want k%0d %02h l%0d s%0d v%0d",
                    kind, data, last, stg, shw,
                    r.kind, r.data, r.last, r.stage, r.shown));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          cycles;
    int          items_sent;
    int          burst_left;
    bit          hold_req;
    int          hold_cnt;

    slhfp_in_if  in_ch();
    slhfp_out_if out_ch();
    link_scoreboard sb;

    serial_link_handshake_field_parser DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: check results, stall on a rotating pattern, hold off on request
    initial begin
        int mode;
        out_ch.ready = 1'b0;
        hold_cnt = 0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready && i_rst_n)
                sb.check(out_ch.kind, out_ch.out_byte, out_ch.last,
                         out_ch.stage, out_ch.show_stats);
            if (hold_req && hold_cnt == 0) begin
                hold_cnt = HOLD_CYCLES;
                hold_req = 0;
            end
            mode = (cycles / 97) % 4;
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end else if (mode == 0) begin
                out_ch.ready <= 1'b1;
            end else if (mode == 1) begin
                out_ch.ready <= cycles[0];
            end else if (mode == 2) begin
                out_ch.ready <= ($urandom_range(9) < 3);
            end else begin
                out_ch.ready <= ($urandom_range(9) < 8);
            end
        end
    end

    // Offer one transaction and hold it until accepted, bursts with gaps
    task send_item(t_op op, logic [7:0] b, logic [3:0] slot, logic [4:0] idx);
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.data_byte  <= b;
        in_ch.field_slot <= slot;
        in_ch.char_index <= idx;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(op, b, slot, idx);
        if (op != OP_IGNORE) items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(12);
            if ($urandom_range(3) != 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    task send_byte(logic [7:0] b);
        send_item(OP_BYTE, b, 4'($urandom), 5'($urandom));
    endtask

    task send_line(logic [7:0] s[$]);
        foreach (s[i]) send_byte(s[i]);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    task send_tick();
        send_item(OP_TICK, 8'($urandom), 4'($urandom), 5'($urandom));
    endtask

    task send_read(logic [3:0] slot, logic [4:0] idx);
        send_item(OP_READ, 8'($urandom), slot, idx);
    endtask

    // Stats line with random field contents; count of separators mostly right
    task send_stats(bit nine);
        logic [7:0] s[$];
        int nf;
        int len;
        nf = nine ? 9 : 3;
        if ($urandom_range(7) == 0) nf = nf + $urandom_range(2) - 1;
        s = '{8'h44, 8'h11, nine ? 8'h31 : 8'h30};
        if ($urandom_range(15) == 0) s[2] = 8'($urandom);
        for (int f = 0; f < nf; f++) begin
            len = nine ? $urandom_range(4) : $urandom_range(1, 18);
            if ($urandom_range(9) == 0) len = 0;
            repeat (len) s.push_back(8'($urandom_range(8'h20, 8'hFF)));
            s.push_back(UNIT_SEP);
        end
        send_line(s);
    endtask

    task link_up();
        send_line('{8'h4A, 8'h42, 8'h05});
        send_line('{8'h50, ($urandom_range(9) == 0) ? 8'h15 : 8'h06});
    endtask

    // Register write: setup cycle then access cycle
    task write_timeout(logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        sb.timeout_ticks = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Let the block drain completely before touching the register
    task drain();
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task random_phase(int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                link_up();
            end else if (pick < 50) begin
                send_stats($urandom_range(1));
            end else if (pick < 58) begin
                send_line('{8'h48, 8'h30});
            end else if (pick < 72) begin
                repeat ($urandom_range(1, 5)) send_tick();
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4))
                    send_read(4'($urandom_range(15)), 5'($urandom_range(31)));
            end else begin
                send_item(t_op'($urandom_range(3)), 8'($urandom),
                          4'($urandom), 5'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        items_sent = 0;
        burst_left = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_BYTE;
        in_ch.data_byte = 8'h00;
        in_ch.field_slot = 4'd0;
        in_ch.char_index = 5'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: out-of-range read, ignored op, handshake, stats and beat
        write_timeout(32'd40);
        send_tick();
        send_read(4'd15, 5'd31);
        send_item(OP_IGNORE, 8'hFF, 4'd0, 5'd0);
        send_byte(8'hFF);
        send_line('{8'h4A, 8'h42, 8'h05});
        send_line('{8'h50, 8'h06});
        send_line('{8'h44, 8'h11, 8'h30, 8'h41, UNIT_SEP, UNIT_SEP, 8'h42, UNIT_SEP});
        send_read(4'd0, 5'd0);
        send_read(4'd1, 5'd0);
        send_read(4'd2, 5'd27);
        send_line('{8'h48, 8'h30});
        drain();

        // Random phases across timeout settings, extremes included
        write_timeout(32'd1);
        random_phase(70);
        drain();
        write_timeout(32'hFFFF_FFFF);
        random_phase(90);
        drain();
        write_timeout(32'($urandom_range(2, 30)));
        hold_req = 1;
        repeat (20) send_read(4'($urandom_range(11)), 5'($urandom_range(27)));
        random_phase(110);
        drain();
        write_timeout(TIMEOUT_RESET);
        random_phase(100);

        drain();
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
